[hw/rtl/sdspi_pkg.sv]
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int CID_BYTES   = 16;
  localparam int IDX_W       = 10;

  localparam logic [1:0] FUNC_DETECT = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_BYTE   = 2'd2;

  localparam logic [1:0] REG_RESP_TO = 2'd0;
  localparam logic [1:0] REG_TOK_TO  = 2'd1;
  localparam logic [1:0] REG_RETRIES = 2'd2;
  localparam logic [1:0] REG_GAP     = 2'd3;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD10 = 6'd10;
  localparam logic [5:0] CMD12 = 6'd12;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD18 = 6'd18;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef enum logic [5:0] {
    PH_IDLE, PH_WAKE, PH_FRAME, PH_R1, PH_R32, PH_TAIL,
    PH_GAP, PH_TOKEN, PH_DATA, PH_CRC, PH_STUFF
  } phase_t;

  typedef enum logic [3:0] {
    GO_FAIL, GO_DONE, GO_CMD8, GO_CMD55, GO_CMD41, GO_CMD58,
    GO_CMD10, GO_CMD16, GO_GAP
  } go_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [31:0] block_address;
    logic [15:0] block_count;
  } in_word_t;

  typedef struct packed {
    logic       xfer_request;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_kind;
    logic       data_last;
    logic       done_res;
    logic       status;
    logic       card_high_capacity;
    logic       card_v2;
  } out_word_t;

  // CRC7 over the first five bytes of a command frame, polynomial 0x89.
  function automatic logic [6:0] crc7(input logic [39:0] five);
    logic [6:0] c;
    logic       fb;
    c = '0;
    for (int i = 39; i >= 0; i--) begin
      fb = c[6] ^ five[i];
      c  = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction

endpackage

[hw/rtl/sdspi_if.sv]
interface sdspi_in_if;
  logic               valid;
  logic               ready;
  sdspi_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_out_if;
  logic                valid;
  logic                ready;
  sdspi_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/sd_spi_card_init_and_read.sv]
// The result word is registered: it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are taken; the result register frees as it is taken.
// The sequencer state and result register form one stage, so a new word is
// accepted whenever the result register is empty or being taken that cycle.
// Reset (synchronous, active high) returns to idle with the default timeouts.
module sd_spi_card_init_and_read (
  input  logic                 clk,
  input  logic                 rst,
  sdspi_in_if.sink             in_ch,
  sdspi_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [19:0]          cfg_data
);
  import sdspi_pkg::*;

  logic [15:0] response_timeout, op_cond_retries, retry_gap_bytes;
  logic [19:0] token_timeout;

  phase_t      phase, phase_next;
  logic [47:0] frame_bytes, frame_bytes_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [6:0]  frame_crc, frame_crc_next;
  logic [19:0] poll_counter, poll_counter_next;
  logic [15:0] retry_counter, retry_counter_next;
  logic [31:0] response_word, response_word_next;
  logic [15:0] blocks_left, blocks_left_next;
  logic        multi_block, multi_block_next;
  logic        is_v2, is_v2_next, is_hc, is_hc_next;
  logic [5:0]  cmd_now, cmd_now_next;
  go_t         tail_next, tail_next_next;
  logic        kind_now, kind_now_next;

  out_word_t   res, out_data;
  logic        out_valid, produce, accept;
  in_word_t    d;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign d            = in_ch.data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout <= 16'd1000;
      token_timeout    <= 20'd100000;
      op_cond_retries  <= 16'd1000;
      retry_gap_bytes  <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESP_TO: response_timeout <= cfg_data[15:0];
        REG_TOK_TO:  token_timeout    <= cfg_data;
        REG_RETRIES: op_cond_retries  <= cfg_data[15:0];
        REG_GAP:     retry_gap_bytes  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Next state and result word.
  always_comb begin
    logic [15:0] resp_lim, retry_lim, cnt;
    logic [19:0] tok_lim;
    logic [39:0] five;
    logic [5:0]  sc_idx;
    logic [31:0] sc_arg;
    logic        sc, bad, ok, fin, fail, do_tail, do_tok;
    go_t         tgo, gsel;
    logic [IDX_W-1:0] len;

    phase_next = phase; frame_bytes_next = frame_bytes; byte_index_next = byte_index;
    frame_crc_next = frame_crc; poll_counter_next = poll_counter;
    retry_counter_next = retry_counter; response_word_next = response_word;
    blocks_left_next = blocks_left; multi_block_next = multi_block;
    is_v2_next = is_v2; is_hc_next = is_hc; cmd_now_next = cmd_now;
    tail_next_next = tail_next; kind_now_next = kind_now;
    res = '0; res.tx_byte = 8'hFF;
    produce = 1'b0;
    resp_lim  = (response_timeout == 16'd0) ? 16'd1 : response_timeout;
    retry_lim = (op_cond_retries == 16'd0) ? 16'd1 : op_cond_retries;
    tok_lim   = (token_timeout == 20'd0) ? 20'd1 : token_timeout;
    cnt = d.block_count;
    five = '0;
    sc = 1'b0; sc_idx = CMD0; sc_arg = '0;
    fin = 1'b0; fail = 1'b0; do_tail = 1'b0; do_tok = 1'b0; tgo = GO_FAIL;
    ok = 1'b0; bad = 1'b0; gsel = tail_next;
    len = kind_now ? IDX_W'(CID_BYTES) : IDX_W'(BLOCK_BYTES);

    if (accept) begin
      if (d.func == FUNC_DETECT || d.func == FUNC_READ) begin
        if (phase == PH_IDLE) begin
          produce = 1'b1;
          if (d.func == FUNC_DETECT) begin
            is_v2_next = 1'b0; is_hc_next = 1'b0; retry_counter_next = '0;
            phase_next = PH_WAKE; byte_index_next = IDX_W'(1);
            res.xfer_request = 1'b1;
          end else begin
            blocks_left_next = (cnt == 16'd0) ? 16'd1 : cnt;
            multi_block_next = cnt > 16'd1;
            sc = 1'b1; sc_idx = (cnt > 16'd1) ? CMD18 : CMD17;
            sc_arg = d.block_address;
          end
        end
      end else if (d.func == FUNC_BYTE && phase != PH_IDLE) begin
        produce = 1'b1;
        case (phase)
          PH_WAKE: begin
            if (byte_index < IDX_W'(10)) begin
              byte_index_next = byte_index + 1'b1;
              res.xfer_request = 1'b1;
            end else begin
              sc = 1'b1; sc_idx = CMD0;
            end
          end
          PH_FRAME: begin
            if (byte_index < IDX_W'(6)) begin
              res.xfer_request = 1'b1; res.select_active = 1'b1;
              res.tx_byte = frame_bytes[47 - 8*byte_index[2:0] -: 8];
              byte_index_next = byte_index + 1'b1;
            end else begin
              phase_next = PH_R1; poll_counter_next = 20'd1;
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end
          end
          PH_R1: begin
            if (!d.rx_byte[7] || poll_counter >= {4'd0, resp_lim}) begin
              ok  = !d.rx_byte[7];
              bad = !ok || (d.rx_byte & 8'h7E) != 8'h00;
              case (cmd_now)
                CMD0: begin
                  do_tail = 1'b1;
                  tgo = (ok && d.rx_byte == 8'h01) ? GO_CMD8 : GO_FAIL;
                end
                CMD8, CMD58: begin
                  if (bad) begin
                    do_tail = 1'b1; tgo = (cmd_now == CMD8) ? GO_CMD55 : GO_CMD10;
                  end else begin
                    phase_next = PH_R32; byte_index_next = '0; response_word_next = '0;
                    res.xfer_request = 1'b1; res.select_active = 1'b1;
                  end
                end
                CMD55: begin do_tail = 1'b1; tgo = bad ? GO_FAIL : GO_CMD41; end
                CMD41: begin
                  do_tail = 1'b1;
                  if (ok && d.rx_byte == 8'h00) begin
                    tgo = is_v2 ? GO_CMD58 : GO_CMD10;
                  end else begin
                    retry_counter_next = retry_counter + 1'b1;
                    tgo = (retry_counter + 16'd1 >= retry_lim) ? GO_FAIL : GO_GAP;
                  end
                end
                CMD10, CMD17, CMD18: begin
                  if (bad) begin
                    do_tail = 1'b1; tgo = GO_FAIL;
                  end else begin
                    kind_now_next = (cmd_now == CMD10); do_tok = 1'b1;
                  end
                end
                CMD16: begin do_tail = 1'b1; tgo = bad ? GO_FAIL : GO_DONE; end
                CMD12: begin
                  phase_next = PH_STUFF;
                  res.xfer_request = 1'b1; res.select_active = 1'b1;
                end
                default: begin do_tail = 1'b1; tgo = GO_FAIL; end
              endcase
            end else begin
              poll_counter_next = poll_counter + 1'b1;
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end
          end
          PH_R32: begin
            response_word_next = {response_word[23:0], d.rx_byte};
            byte_index_next = byte_index + 1'b1;
            if (byte_index + 1'b1 < IDX_W'(4)) begin
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end else if (cmd_now == CMD8) begin
              is_v2_next = d.rx_byte == 8'hAA;
              do_tail = 1'b1; tgo = GO_CMD55;
            end else begin
              is_hc_next = response_word[22];
              do_tail = 1'b1; tgo = GO_CMD10;
            end
          end
          PH_TAIL: begin
            case (gsel)
              GO_DONE:  fin = 1'b1;
              GO_CMD8:  begin sc = 1'b1; sc_idx = CMD8; sc_arg = 32'h0000_01AA; end
              GO_CMD55: begin sc = 1'b1; sc_idx = CMD55; end
              GO_CMD41: begin
                sc = 1'b1; sc_idx = CMD41;
                sc_arg = {1'b0, is_v2, 6'd0, 9'h1FF, 15'd0};
              end
              GO_CMD58: begin sc = 1'b1; sc_idx = CMD58; end
              GO_CMD10: begin sc = 1'b1; sc_idx = CMD10; end
              GO_CMD16: begin sc = 1'b1; sc_idx = CMD16; sc_arg = 32'(BLOCK_BYTES); end
              GO_GAP: begin
                if (retry_gap_bytes == 16'd0) begin
                  sc = 1'b1; sc_idx = CMD55;
                end else begin
                  phase_next = PH_GAP; poll_counter_next = 20'd1;
                  res.xfer_request = 1'b1;
                end
              end
              default: begin fin = 1'b1; fail = 1'b1; end
            endcase
          end
          PH_GAP: begin
            if (poll_counter < {4'd0, retry_gap_bytes}) begin
              poll_counter_next = poll_counter + 1'b1; res.xfer_request = 1'b1;
            end else begin
              sc = 1'b1; sc_idx = CMD55;
            end
          end
          PH_TOKEN: begin
            if (d.rx_byte == 8'hFE) begin
              phase_next = PH_DATA; byte_index_next = '0;
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end else if (d.rx_byte != 8'hFF || poll_counter >= tok_lim) begin
              do_tail = 1'b1; tgo = GO_FAIL;
            end else begin
              poll_counter_next = poll_counter + 1'b1;
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end
          end
          PH_DATA: begin
            byte_index_next = byte_index + 1'b1;
            res.data_valid = 1'b1; res.data_byte = d.rx_byte; res.data_kind = kind_now;
            if (byte_index + 1'b1 >= len) begin
              res.data_last = 1'b1; phase_next = PH_CRC; byte_index_next = '0;
            end
            res.xfer_request = 1'b1; res.select_active = 1'b1;
          end
          PH_CRC: begin
            byte_index_next = byte_index + 1'b1;
            if (byte_index + 1'b1 < IDX_W'(2)) begin
              res.xfer_request = 1'b1; res.select_active = 1'b1;
            end else if (kind_now) begin
              do_tail = 1'b1; tgo = is_hc ? GO_DONE : GO_CMD16;
            end else begin
              if (blocks_left != 16'd0) blocks_left_next = blocks_left - 1'b1;
              if (blocks_left > 16'd1) do_tok = 1'b1;
              else if (multi_block) begin sc = 1'b1; sc_idx = CMD12; end
              else begin do_tail = 1'b1; tgo = GO_DONE; end
            end
          end
          PH_STUFF: begin do_tail = 1'b1; tgo = GO_DONE; end
          default: begin fin = 1'b1; fail = 1'b1; end
        endcase
      end

      // Shared endings: closing byte, token wait, command frame, completion.
      if (do_tail) begin
        phase_next = PH_TAIL; tail_next_next = tgo; res.xfer_request = 1'b1;
      end
      if (do_tok) begin
        phase_next = PH_TOKEN; poll_counter_next = 20'd1;
        res.xfer_request = 1'b1; res.select_active = 1'b1;
      end
      if (sc) begin
        five = {2'b01, sc_idx, sc_arg};
        frame_crc_next = crc7(five);
        frame_bytes_next = {five, crc7(five), 1'b1};
        cmd_now_next = sc_idx; phase_next = PH_FRAME; byte_index_next = IDX_W'(1);
        res.xfer_request = 1'b1; res.select_active = 1'b1;
        res.tx_byte = five[39:32];
      end
      if (fin) begin
        phase_next = PH_IDLE; res.xfer_request = 1'b0; res.select_active = 1'b0;
        res.tx_byte = 8'hFF; res.done_res = 1'b1; res.status = fail;
      end
    end
    res.card_high_capacity = is_hc_next;
    res.card_v2 = is_v2_next;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; frame_bytes <= '0; byte_index <= '0; frame_crc <= '0;
      poll_counter <= '0; retry_counter <= '0; response_word <= '0;
      blocks_left <= '0; multi_block <= 1'b0; is_v2 <= 1'b0; is_hc <= 1'b0;
      cmd_now <= CMD0; tail_next <= GO_FAIL; kind_now <= 1'b0;
    end else begin
      phase <= phase_next; frame_bytes <= frame_bytes_next;
      byte_index <= byte_index_next; frame_crc <= frame_crc_next;
      poll_counter <= poll_counter_next; retry_counter <= retry_counter_next;
      response_word <= response_word_next; blocks_left <= blocks_left_next;
      multi_block <= multi_block_next; is_v2 <= is_v2_next; is_hc <= is_hc_next;
      cmd_now <= cmd_now_next; tail_next <= tail_next_next; kind_now <= kind_now_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && produce) out_data <= res;
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && produce && res.done_res) |=> (phase == PH_IDLE))
    else $error("done word without return to idle");
  a_done_noxfer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.xfer_request)
    else $error("done word requests a transfer");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");
  a_data_sel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.data_valid) |-> out_data.select_active)
    else $error("data word outside a selected transfer");
`endif

endmodule

[sim/sdspi_transfer_check.sv]
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every result word of
// the sequencer and compares it with what the block hands out.
module sdspi_transfer_check (
  input  logic  clk,
  input  logic  rst,
  sdspi_in_if   in_ch,
  sdspi_out_if  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int    errors,
  output int    pending,
  output int    results_seen,
  output int    data_seen
);
  import sdspi_pkg::*;

  // Register copies.
  logic [15:0] resp_limit, retry_limit, gap_len;
  logic [19:0] token_limit;

  // Sequencer state as the predictor sees it.
  phase_t      ph;
  logic [47:0] frame;
  int unsigned idx;
  int unsigned polls;
  logic [15:0] attempts;
  logic [31:0] resp_word;
  int unsigned blocks_left;
  bit          multi, v2, high_cap, cid_kind;
  logic [5:0]  cmd_now;
  go_t         after_tail;

  out_word_t   pred;
  out_word_t   expected_words[$];

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [6:0] frame_crc7(logic [39:0] bits);
    logic [6:0] c;
    logic       fb;
    c = '0;
    for (int i = 39; i >= 0; i--) begin
      fb = c[6] ^ bits[i];
      c  = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction

  function void request(logic [7:0] tx, bit sel);
    pred.xfer_request  = 1'b1;
    pred.tx_byte       = tx;
    pred.select_active = sel;
  endfunction

  function void finish_op(bit fail);
    ph = PH_IDLE;
    pred.xfer_request  = 1'b0;
    pred.tx_byte       = 8'hFF;
    pred.select_active = 1'b0;
    pred.done_res      = 1'b1;
    pred.status        = fail;
  endfunction

  function void issue_cmd(logic [5:0] c, logic [31:0] arg);
    logic [39:0] five;
    logic [6:0]  crc;
    five    = {2'b01, c, arg};
    crc     = frame_crc7(five);
    frame   = {five, crc, 1'b1};
    cmd_now = c;
    ph      = PH_FRAME;
    request(frame[47:40], 1'b1);
    idx     = 1;
  endfunction

  function void to_tail(go_t n);
    ph         = PH_TAIL;
    after_tail = n;
    request(8'hFF, 1'b0);
  endfunction

  function void wait_token();
    ph    = PH_TOKEN;
    polls = 1;
    request(8'hFF, 1'b1);
  endfunction

  function void proceed(go_t n);
    case (n)
      GO_DONE:  finish_op(1'b0);
      GO_CMD8:  issue_cmd(CMD8, 32'h0000_01AA);
      GO_CMD55: issue_cmd(CMD55, '0);
      GO_CMD41: issue_cmd(CMD41, (32'h1FF << 15) | (v2 ? 32'h4000_0000 : 32'h0));
      GO_CMD58: issue_cmd(CMD58, '0);
      GO_CMD10: issue_cmd(CMD10, '0);
      GO_CMD16: issue_cmd(CMD16, BLOCK_BYTES);
      GO_GAP: begin
        if (gap_len == 0) begin
          issue_cmd(CMD55, '0);
        end else begin
          ph    = PH_GAP;
          polls = 1;
          request(8'hFF, 1'b0);
        end
      end
      default:  finish_op(1'b1);
    endcase
  endfunction

  // Handles the R1 byte, or its absence after the poll limit.
  function void r1_seen(bit ok, logic [7:0] r);
    bit bad;
    bad = !ok || ((r & 8'h7E) != 0);
    case (cmd_now)
      CMD0: to_tail((ok && r == 8'h01) ? GO_CMD8 : GO_FAIL);
      CMD8, CMD58: begin
        if (bad) begin
          to_tail(cmd_now == CMD8 ? GO_CMD55 : GO_CMD10);
        end else begin
          ph        = PH_R32;
          idx       = 0;
          resp_word = '0;
          request(8'hFF, 1'b1);
        end
      end
      CMD55: to_tail(bad ? GO_FAIL : GO_CMD41);
      CMD41: begin
        if (ok && r == 8'h00) begin
          to_tail(v2 ? GO_CMD58 : GO_CMD10);
        end else begin
          attempts = attempts + 16'd1;
          to_tail(attempts >= at_least_one(retry_limit) ? GO_FAIL : GO_GAP);
        end
      end
      CMD10, CMD17, CMD18: begin
        if (bad) begin
          to_tail(GO_FAIL);
        end else begin
          cid_kind = (cmd_now == CMD10);
          wait_token();
        end
      end
      CMD16: to_tail(bad ? GO_FAIL : GO_DONE);
      CMD12: begin
        ph = PH_STUFF;
        request(8'hFF, 1'b1);
      end
      default: to_tail(GO_FAIL);
    endcase
  endfunction

  // End of one CID or one data block including its CRC bytes.
  function void unit_complete();
    if (cid_kind) begin
      to_tail(high_cap ? GO_DONE : GO_CMD16);
    end else begin
      if (blocks_left != 0) blocks_left--;
      if (blocks_left != 0) wait_token();
      else if (multi) issue_cmd(CMD12, '0);
      else to_tail(GO_DONE);
    end
  endfunction

  // Returns 1 when the word produces a result, left in pred.
  function bit predict_word(in_word_t w);
    int unsigned len;
    pred = '0;
    if (w.func == FUNC_DETECT || w.func == FUNC_READ) begin
      if (ph != PH_IDLE) return 1'b0;
      if (w.func == FUNC_DETECT) begin
        v2       = 1'b0;
        high_cap = 1'b0;
        attempts = '0;
        ph       = PH_WAKE;
        idx      = 1;
        request(8'hFF, 1'b0);
      end else begin
        blocks_left = at_least_one(w.block_count);
        multi       = w.block_count > 1;
        issue_cmd(multi ? CMD18 : CMD17, w.block_address);
      end
    end else begin
      if (w.func != FUNC_BYTE || ph == PH_IDLE) return 1'b0;
      case (ph)
        PH_WAKE: begin
          if (idx < 10) begin
            idx++;
            request(8'hFF, 1'b0);
          end else begin
            issue_cmd(CMD0, '0);
          end
        end
        PH_FRAME: begin
          if (idx < 6) begin
            request(frame[47 - 8 * idx -: 8], 1'b1);
            idx++;
          end else begin
            ph    = PH_R1;
            polls = 1;
            request(8'hFF, 1'b1);
          end
        end
        PH_R1: begin
          if (!w.rx_byte[7]) r1_seen(1'b1, w.rx_byte);
          else if (polls < at_least_one(resp_limit)) begin
            polls++;
            request(8'hFF, 1'b1);
          end else r1_seen(1'b0, 8'h00);
        end
        PH_R32: begin
          resp_word = {resp_word[23:0], w.rx_byte};
          idx++;
          if (idx < 4) begin
            request(8'hFF, 1'b1);
          end else if (cmd_now == CMD8) begin
            v2 = (resp_word[7:0] == 8'hAA);
            to_tail(GO_CMD55);
          end else begin
            high_cap = resp_word[30];
            to_tail(GO_CMD10);
          end
        end
        PH_TAIL: proceed(after_tail);
        PH_GAP: begin
          if (polls < gap_len) begin
            polls++;
            request(8'hFF, 1'b0);
          end else begin
            issue_cmd(CMD55, '0);
          end
        end
        PH_TOKEN: begin
          if (w.rx_byte == 8'hFE) begin
            ph  = PH_DATA;
            idx = 0;
            request(8'hFF, 1'b1);
          end else if (w.rx_byte != 8'hFF) begin
            to_tail(GO_FAIL);
          end else if (polls < at_least_one(token_limit)) begin
            polls++;
            request(8'hFF, 1'b1);
          end else begin
            to_tail(GO_FAIL);
          end
        end
        PH_DATA: begin
          len = cid_kind ? CID_BYTES : BLOCK_BYTES;
          idx++;
          pred.data_valid = 1'b1;
          pred.data_byte  = w.rx_byte;
          pred.data_kind  = cid_kind;
          if (idx >= len) begin
            pred.data_last = 1'b1;
            ph  = PH_CRC;
            idx = 0;
          end
          request(8'hFF, 1'b1);
        end
        PH_CRC: begin
          idx++;
          if (idx < 2) request(8'hFF, 1'b1);
          else unit_complete();
        end
        PH_STUFF: to_tail(GO_DONE);
        default: finish_op(1'b1);
      endcase
    end
    pred.card_high_capacity = high_cap;
    pred.card_v2            = v2;
    return 1'b1;
  endfunction

  function bit fields_differ(out_word_t e, out_word_t a);
    return e.xfer_request !== a.xfer_request || e.tx_byte !== a.tx_byte
        || e.select_active !== a.select_active || e.data_valid !== a.data_valid
        || e.data_byte !== a.data_byte || e.data_kind !== a.data_kind
        || e.data_last !== a.data_last || e.done_res !== a.done_res
        || e.status !== a.status || e.card_high_capacity !== a.card_high_capacity
        || e.card_v2 !== a.card_v2;
  endfunction

  // Compare first, then registers, then predict for the word taken this edge.
  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      resp_limit   = 16'd1000;
      token_limit  = 20'd100000;
      retry_limit  = 16'd1000;
      gap_len      = 16'd50;
      ph           = PH_IDLE;
      frame        = '0;
      idx          = 0;
      polls        = 0;
      attempts     = '0;
      resp_word    = '0;
      blocks_left  = 0;
      multi        = 1'b0;
      v2           = 1'b0;
      high_cap     = 1'b0;
      cid_kind     = 1'b0;
      cmd_now      = CMD0;
      after_tail   = GO_FAIL;
      expected_words.delete();
      errors       = 0;
      results_seen = 0;
      data_seen    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.data.data_valid) data_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", out_ch.data);
        end else begin
          e = expected_words.pop_front();
          if (fields_differ(e, out_ch.data)) begin
            errors++;
            if (errors <= 10)
              $display("result word differs: expected %p, got %p", e, out_ch.data);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RESP_TO: resp_limit  = cfg_data[15:0];
          REG_TOK_TO:  token_limit = cfg_data;
          REG_RETRIES: retry_limit = cfg_data[15:0];
          REG_GAP:     gap_len     = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_word(in_ch.data)) expected_words.push_back(pred);
      end
    end
    pending = expected_words.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import sdspi_pkg::*;

  // Function code that the sequencer never acts on.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  sdspi_in_if  in_ch();
  sdspi_out_if out_ch();

  int errors, pending, results_seen, data_seen;

  sd_spi_card_init_and_read i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sdspi_transfer_check i_check (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .data_seen    (data_seen)
  );

  // Stimulus state and the simple card that answers the sequencer.
  int          words_sent;
  bit          steady;
  bit          busy;
  int unsigned eff_resp, eff_tok;
  bit          acmd_always_ready;
  int unsigned acmd_busy;
  int unsigned frame_cnt;
  logic [5:0]  cmd_seen;
  logic [15:0] read_count;
  logic [7:0]  card_bytes[$];
  out_word_t   taken_words[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result side: stalls at random except in the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
      if (out_ch.valid && out_ch.ready) taken_words.push_back(out_ch.data);
    end
  end

  // Sends one word and waits for it to be taken.
  task automatic put_word(in_word_t w, bit counts);
    if (!steady) begin
      while ($urandom_range(0, 99) < 31) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    if (counts) words_sent++;
    steady = (words_sent >= 700 && words_sent < 1000);
  endtask

  task automatic put_rand(logic [1:0] f, logic [7:0] rx, bit counts);
    in_word_t w;
    w.func          = f;
    w.rx_byte       = rx;
    w.block_address = $urandom;
    w.block_count   = 16'($urandom);
    put_word(w, counts);
  endtask

  // A word the sequencer must ignore, followed by a pause in sending.
  task automatic put_ignored();
    logic [1:0] f;
    if (busy) begin
      if ($urandom_range(0, 2) == 0) f = FUNC_UNUSED;
      else f = ($urandom_range(0, 1) == 0) ? FUNC_DETECT : FUNC_READ;
    end else begin
      f = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED : FUNC_BYTE;
    end
    put_rand(f, 8'($urandom), 1'b0);
    @(posedge clk);
  endtask

  function automatic int unsigned upto(int unsigned lim, int unsigned cap);
    return (lim - 1 < cap) ? lim - 1 : cap;
  endfunction

  function void push_r1(logic [7:0] v);
    repeat ($urandom_range(0, upto(eff_resp, 3))) card_bytes.push_back(8'hFF);
    card_bytes.push_back(v);
  endfunction

  // Token, payload and CRC of one CID or data block, sometimes spoilt.
  function void push_unit(int n, bit spoil);
    repeat ($urandom_range(0, upto(eff_tok, 4))) card_bytes.push_back(8'hFF);
    if (spoil || $urandom_range(0, 11) == 0) begin
      card_bytes.push_back(8'($urandom_range(0, 253)));
      return;
    end
    if (eff_tok <= 30 && $urandom_range(0, 11) == 0) return;
    card_bytes.push_back(8'hFE);
    repeat (n + 2) card_bytes.push_back(8'($urandom));
  endfunction

  // Builds the card's answer to a complete command frame.
  function void card_reply();
    if (eff_resp <= 10 && $urandom_range(0, 19) == 0) return;
    case (cmd_seen)
      CMD0: begin
        acmd_busy = acmd_always_ready ? 0 : $urandom_range(0, 3);
        push_r1(($urandom_range(0, 14) == 0) ? 8'h05 : 8'h01);
      end
      CMD8: begin
        if ($urandom_range(0, 4) == 0) begin
          push_r1(8'h05);
        end else begin
          push_r1(8'h01);
          card_bytes.push_back(8'h00);
          card_bytes.push_back(8'h00);
          card_bytes.push_back(8'h01);
          card_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hAA);
        end
      end
      CMD55: push_r1(($urandom_range(0, 29) == 0) ? 8'h04 : 8'h01);
      CMD41: begin
        if (acmd_busy > 0) begin
          acmd_busy--;
          push_r1(8'h01);
        end else begin
          push_r1(8'h00);
        end
      end
      CMD58: begin
        if ($urandom_range(0, 7) == 0) begin
          push_r1(8'h05);
        end else begin
          push_r1(8'h00);
          repeat (4) card_bytes.push_back(8'($urandom));
        end
      end
      CMD10: begin
        push_r1(8'h00);
        push_unit(CID_BYTES, 1'b0);
      end
      CMD16: push_r1(($urandom_range(0, 9) == 0) ? 8'h04 : 8'h00);
      CMD17, CMD18: begin
        if ($urandom_range(0, 14) == 0) begin
          push_r1(8'h04);
        end else begin
          push_r1(8'h00);
          push_unit(BLOCK_BYTES, 1'b0);
          if (cmd_seen == CMD18) push_unit(BLOCK_BYTES, read_count > 2);
        end
      end
      CMD12: push_r1(8'($urandom_range(0, 127)));
      default: ;
    endcase
  endfunction

  // Byte the card returns during the transfer that r asks for.
  function logic [7:0] card_answer(out_word_t r);
    if (!r.select_active) return 8'($urandom);
    if (frame_cnt == 0 && r.tx_byte[7:6] == 2'b01) begin
      card_bytes.delete();
      cmd_seen  = r.tx_byte[5:0];
      frame_cnt = 1;
      return 8'($urandom);
    end
    if (frame_cnt != 0) begin
      frame_cnt++;
      if (frame_cnt == 6) begin
        frame_cnt = 0;
        card_reply();
      end
      return 8'($urandom);
    end
    if (card_bytes.size() != 0) return card_bytes.pop_front();
    return 8'hFF;
  endfunction

  // One detect or read from start word to the finishing result.
  task automatic run_operation(bit do_read);
    in_word_t  w;
    out_word_t r;
    logic [7:0] rx;
    w.func    = do_read ? FUNC_READ : FUNC_DETECT;
    w.rx_byte = 8'($urandom);
    w.block_address = $urandom;
    case ($urandom_range(0, 9))
      0:       w.block_count = 16'd0;
      1:       w.block_count = 16'd2;
      2:       w.block_count = 16'hFFFF;
      3, 4:    w.block_count = 16'($urandom_range(3, 65534));
      default: w.block_count = 16'd1;
    endcase
    read_count = w.block_count;
    frame_cnt  = 0;
    card_bytes.delete();
    put_word(w, 1'b1);
    busy = 1'b1;
    forever begin
      while (taken_words.size() == 0) @(posedge clk);
      r = taken_words.pop_front();
      if (r.done_res) break;
      rx = card_answer(r);
      if ($urandom_range(0, 19) == 0) put_ignored();
      put_rand(FUNC_BYTE, rx, 1'b1);
    end
    busy = 1'b0;
    if ($urandom_range(0, 4) == 0) put_ignored();
  endtask

  // Register writes while the sequencer is idle.
  task automatic set_regs(logic [15:0] resp, logic [19:0] tok, logic [15:0] tries,
                          logic [15:0] gap);
    logic [19:0] vals[4];
    vals = '{20'(resp), tok, 20'(tries), 20'(gap)};
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    eff_resp = (resp == 0) ? 1 : resp;
    eff_tok  = (tok == 0) ? 1 : tok;
  endtask

  task automatic run_until(int target);
    while (words_sent < target) run_operation($urandom_range(0, 9) < 4);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_RESP_TO;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    words_sent   = 0;
    steady       = 1'b0;
    busy         = 1'b0;
    eff_resp     = 1000;
    eff_tok      = 100000;
    acmd_always_ready = 1'b0;
    acmd_busy    = 0;
    frame_cnt    = 0;
    cmd_seen     = CMD0;
    read_count   = 16'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening: a read before any detect, then a detect, at reset settings.
    run_operation(1'b1);
    run_operation(1'b0);
    run_until(350);
    // Zero registers, which behave as one and a gap of none.
    set_regs(16'd0, 20'd0, 16'd0, 16'd0);
    run_until(700);
    // Tight limits so that timeouts and exhausted retries occur.
    set_regs(16'd2, 20'd3, 16'd3, 16'd2);
    run_until(1050);
    // Largest values; the card is never busy, so nothing waits them out.
    acmd_always_ready = 1'b1;
    set_regs(16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    run_until(1400);
    acmd_always_ready = 1'b0;
    set_regs(16'd8, 20'd20, 16'd6, 16'd5);
    run_until(1750);

    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Sent %0d words over five register settings; %0d results checked, %0d data.",
             words_sent, results_seen, data_seen);
    if (errors == 0) begin
      $display("sd_spi_card_init_and_read: match");
    end else begin
      $display("%0d result words were wrong", errors);
      $display("sd_spi_card_init_and_read: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("run did not complete in time");
    $display("sd_spi_card_init_and_read: mismatch");
    $finish;
  end

endmodule

[files.f]
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_if.sv
hw/rtl/sd_spi_card_init_and_read.sv
sim/sdspi_transfer_check.sv
sim/tb.sv
